### rtl/apag_pkg.sv
// ----------------------------------------------------------------------------
// apag_pkg
// Shared types and constants of the peak-envelope automatic gain control.
// ----------------------------------------------------------------------------
package apag_pkg;

    localparam logic [12:0] MAX_FRAMES      = 13'd4096;
    localparam logic [3:0]  MAX_CHANNELS    = 4'd8;
    localparam logic [16:0] ONE_Q16         = 17'd65536;
    localparam logic [18:0] MAX_GAIN_Q16    = 19'd262144;
    localparam logic [16:0] SILENCE_Q16     = 17'd1310;
    // 0.89 in q16 shifted up by 16 bits, the dividend of the target gain
    localparam logic [31:0] TARGET_DIVIDEND = 32'hE3D7_0000;
    localparam logic [31:0] ONE_Q31         = 32'h8000_0000;
    localparam int          DIV_STEPS       = 32;
    localparam int          JOBQ_DEPTH      = 2;

    localparam logic [2:0] CFG_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_CHANNELS = 3'd1;
    localparam logic [2:0] CFG_STREAM   = 3'd2;
    localparam logic [2:0] CFG_MAIN     = 3'd3;
    localparam logic [2:0] CFG_DECAY    = 3'd4;
    localparam logic [2:0] CFG_RISE     = 3'd5;
    localparam logic [2:0] CFG_FALL     = 3'd6;

    typedef struct packed {
        logic        enable;
        logic [3:0]  channels;
        logic [16:0] stream_vol;
        logic [16:0] main_vol;
        logic [31:0] decay;
        logic [31:0] rise;
        logic [31:0] fall;
    } cfg_t;

    typedef struct packed {
        logic [16:0] peak;
        logic [12:0] frames;
    } job_t;

    typedef struct packed {
        logic [18:0] combined_gain;
        logic [18:0] auto_gain;
        logic [16:0] envelope;
        logic        gain_updated;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POW_MUL,
        S_POW_SQ,
        S_ENV,
        S_DIV,
        S_TGT,
        S_GAIN,
        S_COMB_A,
        S_COMB_B
    } back_state_t;

endpackage

### rtl/audio_peak_auto_gain.sv
// ----------------------------------------------------------------------------
// audio_peak_auto_gain
// Boost-only automatic gain control driven by a decaying peak envelope.
//
// channel   handshake          payload
// input     push / full        sample[15:0] signed, buffer_end
// result    empty / pop        combined_gain, auto_gain, envelope, gain_updated
// config    cfg_we             cfg_index[2:0], cfg_data[31:0]
//
// one sample word is taken per cycle while full is low; full rises only when both summaries in
// the job queue wait on the back sequencer.
// a buffer end costs the back part up to two powers, a restoring division and
// the gain and combining steps, all done in turn, set by the one shared
// 32x32 multiplier and the bit-serial divider.
// one result word is held until popped; the next buffer waits in the queue.
// reset clears counters and envelope and sets gain to unity; configuration takes its defaults.
// ----------------------------------------------------------------------------
module audio_peak_auto_gain (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] sample,
    input  logic        buffer_end,
    output logic        empty,
    input  logic        pop,
    output logic [18:0] combined_gain,
    output logic [18:0] auto_gain,
    output logic [16:0] envelope,
    output logic        gain_updated,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import apag_pkg::*;

    cfg_t    cfg_reg;
    logic    gain_reset;
    logic    accept;
    logic    job_push;
    job_t    job_in;
    job_t    job_out;
    logic    job_valid;
    logic    job_pop;
    logic    q_full;
    logic    res_valid;
    result_t res;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign gain_reset = cfg_we && (cfg_index == CFG_ENABLE) && (cfg_data[0] != cfg_reg.enable);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.channels   <= 4'd2;
            cfg_reg.stream_vol <= ONE_Q16;
            cfg_reg.main_vol   <= ONE_Q16;
            cfg_reg.decay      <= 32'd2147468734;
            cfg_reg.rise       <= 32'd2147499107;
            cfg_reg.fall       <= 32'd2147271606;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:   cfg_reg.enable     <= cfg_data[0];
                CFG_CHANNELS: cfg_reg.channels   <= cfg_data[3:0];
                CFG_STREAM:   cfg_reg.stream_vol <= cfg_data[16:0];
                CFG_MAIN:     cfg_reg.main_vol   <= cfg_data[16:0];
                CFG_DECAY:    cfg_reg.decay      <= cfg_data;
                CFG_RISE:     cfg_reg.rise       <= cfg_data;
                CFG_FALL:     cfg_reg.fall       <= cfg_data;
                default:      ;
            endcase
        end
    end

    apag_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .sample     (sample),
        .buffer_end (buffer_end),
        .channels   (cfg_reg.channels),
        .job_push   (job_push),
        .job        (job_in)
    );

    apag_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_push),
        .wr_data (job_in),
        .rd      (job_pop),
        .rd_data (job_out),
        .valid   (job_valid),
        .full    (q_full)
    );

    apag_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .gain_reset (gain_reset),
        .job_valid  (job_valid),
        .job        (job_out),
        .job_pop    (job_pop),
        .pop        (pop),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign empty         = !res_valid;
    assign combined_gain = res.combined_gain;
    assign auto_gain     = res.auto_gain;
    assign envelope      = res.envelope;
    assign gain_updated  = res.gain_updated;

`ifndef SYNTH
    // envelope is a max of clamped values, never above full scale
    a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> envelope <= ONE_Q16)
        else $error("envelope above full scale");

    // a recomputed gain implies an envelope above the silence level
    a_upd_silence: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && gain_updated) |-> envelope > SILENCE_Q16)
        else $error("gain updated on silence");

    // combined gain is saturated
    a_comb_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> combined_gain <= MAX_GAIN_Q16)
        else $error("combined gain not saturated");
`endif

endmodule

### rtl/apag_jobq.sv
// ----------------------------------------------------------------------------
// apag_jobq
// Short queue of finished buffer summaries between the front and back parts.
// ----------------------------------------------------------------------------
module apag_jobq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  apag_pkg::job_t wr_data,
    input  logic          rd,
    output apag_pkg::job_t rd_data,
    output logic          valid,
    output logic          full
);
    import apag_pkg::*;

    localparam int PTR_W = $clog2(JOBQ_DEPTH);

    job_t                   mem [JOBQ_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W:0]         count_reg;

    assign valid   = (count_reg != '0);
    assign full    = (count_reg == (PTR_W+1)'(JOBQ_DEPTH));
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd && valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PTR_W+1)'(wr && !full) - (PTR_W+1)'(rd && valid);
        end
    end

endmodule

### rtl/apag_front.sv
// ----------------------------------------------------------------------------
// apag_front
// Per-sample peak tracking and frame counting; hands a summary per buffer.
// ----------------------------------------------------------------------------
module apag_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [15:0]    sample,
    input  logic           buffer_end,
    input  logic [3:0]     channels,
    output logic           job_push,
    output apag_pkg::job_t job
);
    import apag_pkg::*;

    logic [16:0] partial_reg, partial_next;
    logic [16:0] peak_reg, peak_next;
    logic [2:0]  pos_reg, pos_next;
    logic [12:0] frames_reg, frames_next;

    logic [3:0]  chans;
    logic [15:0] abs_val;
    logic [16:0] mag;
    logic [16:0] part_max;
    logic [3:0]  pos_inc;

    always_comb
    begin
        chans    = (channels > MAX_CHANNELS) ? MAX_CHANNELS : channels;
        // -32768 wraps to 0x8000, which is the right magnitude unsigned
        abs_val  = sample[15] ? 16'(-sample) : sample;
        mag      = {abs_val, 1'b0};
        part_max = (mag > partial_reg) ? mag : partial_reg;
        pos_inc  = {1'b0, pos_reg} + 4'd1;

        partial_next = partial_reg;
        peak_next    = peak_reg;
        pos_next     = pos_reg;
        frames_next  = frames_reg;

        if (chans != 4'd0)
        begin
            if (pos_inc >= chans)
            begin
                peak_next    = (part_max > peak_reg) ? part_max : peak_reg;
                partial_next = '0;
                pos_next     = '0;
                if (frames_reg < MAX_FRAMES)
                begin
                    frames_next = frames_reg + 13'd1;
                end
            end
            else
            begin
                partial_next = part_max;
                pos_next     = pos_inc[2:0];
            end
        end

        job_push   = accept && buffer_end;
        job.peak   = peak_next;
        job.frames = frames_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            peak_reg    <= '0;
            pos_reg     <= '0;
            frames_reg  <= '0;
        end
        else if (accept)
        begin
            if (buffer_end)
            begin
                partial_reg <= '0;
                peak_reg    <= '0;
                pos_reg     <= '0;
                frames_reg  <= '0;
            end
            else
            begin
                partial_reg <= partial_next;
                peak_reg    <= peak_next;
                pos_reg     <= pos_next;
                frames_reg  <= frames_next;
            end
        end
    end

endmodule

### rtl/apag_back.sv
// ----------------------------------------------------------------------------
// apag_back
// Buffer-end sequencer: powers, envelope, target division, gain, result word.
// ----------------------------------------------------------------------------
module apag_back (
    input  logic              clk,
    input  logic              rst_n,
    input  apag_pkg::cfg_t    cfg,
    input  logic              gain_reset,
    input  logic              job_valid,
    input  apag_pkg::job_t    job,
    output logic              job_pop,
    input  logic              pop,
    output logic              res_valid,
    output apag_pkg::result_t res
);
    import apag_pkg::*;

    back_state_t state_reg, state_next;
    logic        res_valid_reg, res_valid_next;
    logic [16:0] env_reg, env_next;
    logic [31:0] gain_reg, gain_next;

    logic        phase_reg, phase_next;
    logic [12:0] n_reg, n_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] base_reg, base_next;
    logic [16:0] peak_reg, peak_next;
    logic [12:0] fc_reg, fc_next;
    logic [16:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [18:0] tgt_reg, tgt_next;
    logic        up_reg, up_next;
    logic        upd_reg, upd_next;
    logic [31:0] comb_reg, comb_next;
    result_t     res_reg, res_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] pow_sat;
    logic [32:0] scaled;
    logic [16:0] dec;
    logic [16:0] env_new;
    logic [17:0] rem_sh;
    logic [32:0] gain_cap;
    logic [47:0] comb_full;

    assign mul_p     = 64'(mul_a) * 64'(mul_b);
    assign pow_sat   = mul_p[63] ? 32'hFFFF_FFFF : mul_p[62:31];
    assign scaled    = mul_p[63:31];
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !pop;
        env_next       = env_reg;
        gain_next      = gain_reg;
        phase_next     = phase_reg;
        n_next         = n_reg;
        r_next         = r_reg;
        base_next      = base_reg;
        peak_next      = peak_reg;
        fc_next        = fc_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        tgt_next       = tgt_reg;
        up_next        = up_reg;
        upd_next       = upd_reg;
        comb_next      = comb_reg;
        res_next       = res_reg;
        job_pop        = 1'b0;
        mul_a          = r_reg;
        mul_b          = base_reg;
        dec            = '0;
        env_new        = '0;
        rem_sh         = '0;
        gain_cap       = '0;
        comb_full      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid && !res_valid_reg)
                begin
                    job_pop   = 1'b1;
                    peak_next = job.peak;
                    fc_next   = job.frames;
                    if (cfg.enable && job.frames != '0)
                    begin
                        r_next     = ONE_Q31;
                        base_next  = cfg.decay;
                        n_next     = job.frames;
                        phase_next = 1'b0;
                        state_next = S_POW_MUL;
                    end
                    else
                    begin
                        upd_next   = 1'b0;
                        state_next = S_COMB_A;
                    end
                end
            end
            S_POW_MUL:
            begin
                if (n_reg[0])
                begin
                    r_next = pow_sat;
                end
                state_next = S_POW_SQ;
            end
            S_POW_SQ:
            begin
                mul_a  = base_reg;
                mul_b  = base_reg;
                n_next = n_reg >> 1;
                if (n_next != '0)
                begin
                    base_next  = pow_sat;
                    state_next = S_POW_MUL;
                end
                else
                begin
                    state_next = phase_reg ? S_GAIN : S_ENV;
                end
            end
            S_ENV:
            begin
                mul_a    = {15'd0, env_reg};
                mul_b    = r_reg;
                dec      = (scaled > 33'(ONE_Q16)) ? ONE_Q16 : scaled[16:0];
                env_new  = (peak_reg > dec) ? peak_reg : dec;
                env_next = env_new;
                if (env_new > SILENCE_Q16)
                begin
                    rem_next   = '0;
                    quo_next   = TARGET_DIVIDEND;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    upd_next   = 1'b0;
                    state_next = S_COMB_A;
                end
            end
            S_DIV:
            begin
                // restoring division, one quotient bit a cycle
                rem_sh = {rem_reg, quo_reg[31]};
                if (rem_sh >= {1'b0, env_reg})
                begin
                    rem_next = 17'(rem_sh - {1'b0, env_reg});
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[16:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = S_TGT;
                end
            end
            S_TGT:
            begin
                if (quo_reg < 32'(ONE_Q16))
                begin
                    tgt_next = 19'(ONE_Q16);
                end
                else if (quo_reg > 32'(MAX_GAIN_Q16))
                begin
                    tgt_next = MAX_GAIN_Q16;
                end
                else
                begin
                    tgt_next = quo_reg[18:0];
                end
                up_next    = (32'(tgt_next) > gain_reg);
                base_next  = up_next ? cfg.rise : cfg.fall;
                r_next     = ONE_Q31;
                n_next     = fc_reg;
                phase_next = 1'b1;
                state_next = S_POW_MUL;
            end
            S_GAIN:
            begin
                mul_a = gain_reg;
                mul_b = r_reg;
                if (up_reg)
                begin
                    gain_cap  = (scaled > 33'(MAX_GAIN_Q16)) ? 33'(MAX_GAIN_Q16) : scaled;
                    gain_next = (gain_cap < 33'(tgt_reg)) ? gain_cap[31:0] : 32'(tgt_reg);
                end
                else
                begin
                    gain_next = (scaled > 33'(tgt_reg)) ? scaled[31:0] : 32'(tgt_reg);
                end
                upd_next   = 1'b1;
                state_next = S_COMB_A;
            end
            S_COMB_A:
            begin
                mul_a      = {15'd0, cfg.stream_vol};
                mul_b      = {15'd0, cfg.main_vol};
                comb_next  = mul_p[47:16];
                state_next = S_COMB_B;
            end
            S_COMB_B:
            begin
                mul_a     = comb_reg;
                mul_b     = gain_reg;
                comb_full = mul_p[63:16];
                res_next.combined_gain = (comb_full > 48'(MAX_GAIN_Q16))
                                         ? MAX_GAIN_Q16 : comb_full[18:0];
                res_next.auto_gain     = gain_reg[18:0];
                res_next.envelope      = env_reg;
                res_next.gain_updated  = upd_reg;
                res_valid_next         = 1'b1;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // enable change: back to unity gain, empty envelope
        if (gain_reset)
        begin
            gain_next = 32'(ONE_Q16);
            env_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            env_reg       <= '0;
            gain_reg      <= 32'(ONE_Q16);
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            env_reg       <= env_next;
            gain_reg      <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        n_reg     <= n_next;
        r_reg     <= r_next;
        base_reg  <= base_next;
        peak_reg  <= peak_next;
        fc_reg    <= fc_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        tgt_reg   <= tgt_next;
        up_reg    <= up_next;
        upd_reg   <= upd_next;
        comb_reg  <= comb_next;
        res_reg   <= res_next;
    end

endmodule

### tb/sv/audio_peak_auto_gain_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_peak_auto_gain_tb
// Drives sample words into the peak-envelope gain block under random push
// bursts and pop stalls. A model of the envelope and gain is kept alongside
// the block, and every result word is checked field by field against it.
// ----------------------------------------------------------------------------
module audio_peak_auto_gain_tb;
    import apag_pkg::*;

    typedef struct {
        logic [18:0] comb;
        logic [18:0] gain;
        logic [16:0] env;
        logic        upd;
    } gain_word_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [15:0] sample;
    logic        buffer_end;
    logic        empty;
    logic        pop;
    logic [18:0] combined_gain;
    logic [18:0] auto_gain;
    logic [16:0] envelope;
    logic        gain_updated;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    audio_peak_auto_gain uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .sample(sample), .buffer_end(buffer_end), .empty(empty), .pop(pop),
        .combined_gain(combined_gain), .auto_gain(auto_gain),
        .envelope(envelope), .gain_updated(gain_updated),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model copy of settings and state
    logic        m_enable;
    logic [3:0]  m_chans;
    logic [16:0] m_svol;
    logic [16:0] m_mvol;
    logic [31:0] m_decay;
    logic [31:0] m_rise;
    logic [31:0] m_fall;
    logic [16:0] m_buf_peak;
    logic [16:0] m_part_peak;
    int unsigned m_pos;
    int unsigned m_frames;
    logic [16:0] m_env;
    // gain state is kept 32 bits wide; a fall factor above one can push it past 19 bits
    logic [31:0] m_gain;

    gain_word_t  pending_words[$];
    int          errors;
    bit          hold_off;
    bit          no_stall;
    int          lull_max;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [31:0] q31_mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = ({32'd0, a} * {32'd0, b}) >> 31;
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic logic [31:0] q31_power(input logic [31:0] base, input int unsigned n);
        logic [31:0] r;
        r = ONE_Q31;
        while (n != 0)
        begin
            if (n & 1)
                r = q31_mul(r, base);
            n = n >> 1;
            if (n != 0)
                base = q31_mul(base, base);
        end
        return r;
    endfunction

    task automatic model_write(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            CFG_ENABLE:
                if (val[0] != m_enable)
                begin
                    m_enable = val[0];
                    m_gain = 32'd65536;
                    m_env = '0;
                end
            CFG_CHANNELS: m_chans = val[3:0];
            CFG_STREAM:   m_svol = val[16:0];
            CFG_MAIN:     m_mvol = val[16:0];
            CFG_DECAY:    m_decay = val;
            CFG_RISE:     m_rise = val;
            CFG_FALL:     m_fall = val;
            default: ;
        endcase
    endtask

    task automatic predict_gain(input logic [15:0] s, input logic last);
        logic [16:0] mag;
        int unsigned chans;
        logic [63:0] dec;
        logic [63:0] tgt;
        logic [63:0] step;
        logic [63:0] comb;
        gain_word_t  w;
        mag = s[15] ? ({1'b0, 16'h0 - s}) : {1'b0, s};
        if (s == 16'h8000)
            mag = 17'd32768;
        mag = mag << 1;
        chans = (m_chans > MAX_CHANNELS) ? MAX_CHANNELS : m_chans;
        if (chans != 0)
        begin
            if (mag > m_part_peak)
                m_part_peak = mag;
            m_pos++;
            if (m_pos >= chans)
            begin
                if (m_part_peak > m_buf_peak)
                    m_buf_peak = m_part_peak;
                m_part_peak = '0;
                m_pos = 0;
                if (m_frames < MAX_FRAMES)
                    m_frames++;
            end
        end
        if (!last)
            return;
        w.upd = 1'b0;
        if (m_enable && m_frames != 0)
        begin
            dec = ({47'd0, m_env} * {32'd0, q31_power(m_decay, m_frames)}) >> 31;
            if (dec > 64'd65536)
                dec = 64'd65536;
            m_env = (m_buf_peak > dec[16:0]) ? m_buf_peak : dec[16:0];
            if (m_env > SILENCE_Q16)
            begin
                tgt = {32'd0, TARGET_DIVIDEND} / {47'd0, m_env};
                if (tgt < 64'd65536)
                    tgt = 64'd65536;
                if (tgt > 64'd262144)
                    tgt = 64'd262144;
                if (tgt > {32'd0, m_gain})
                begin
                    step = ({32'd0, m_gain} * {32'd0, q31_power(m_rise, m_frames)}) >> 31;
                    if (step > 64'd262144)
                        step = 64'd262144;
                    m_gain = (step < tgt) ? step[31:0] : tgt[31:0];
                end
                else
                begin
                    step = ({32'd0, m_gain} * {32'd0, q31_power(m_fall, m_frames)}) >> 31;
                    m_gain = (step > tgt) ? step[31:0] : tgt[31:0];
                end
                w.upd = 1'b1;
            end
        end
        m_buf_peak = '0;
        m_part_peak = '0;
        m_pos = 0;
        m_frames = 0;
        comb = ({47'd0, m_svol} * {47'd0, m_mvol}) >> 16;
        comb = (comb * {32'd0, m_gain}) >> 16;
        if (comb > 64'd262144)
            comb = 64'd262144;
        w.comb = comb[18:0];
        w.gain = m_gain[18:0];
        w.env = m_env;
        pending_words.push_back(w);
    endtask

    // result checker and receiver stall pattern
    always @(posedge clk)
    begin
        gain_word_t w;
        if (rst_n && pop && !empty)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word gain=%0d", $time, auto_gain);
                errors++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (combined_gain !== w.comb)
                begin
                    $display("%0t: combined_gain exp %0d got %0d", $time, w.comb, combined_gain);
                    errors++;
                end
                if (auto_gain !== w.gain)
                begin
                    $display("%0t: auto_gain exp %0d got %0d", $time, w.gain, auto_gain);
                    errors++;
                end
                if (envelope !== w.env)
                begin
                    $display("%0t: envelope exp %0d got %0d", $time, w.env, envelope);
                    errors++;
                end
                if (gain_updated !== w.upd)
                begin
                    $display("%0t: gain_updated exp %0d got %0d", $time, w.upd, gain_updated);
                    errors++;
                end
            end
        end
        if (hold_off)
            pop <= 1'b0;
        else if (no_stall)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_sample(input logic [15:0] s, input logic last);
        push <= 1'b1;
        sample <= s;
        buffer_end <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_gain(s, last);
        if (lull_max > 0 && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, lull_max))
                @(posedge clk);
        end
    endtask

    task automatic finish_push;
        push <= 1'b0;
        buffer_end <= 1'b0;
    endtask

    task automatic drain;
        int guard;
        finish_push();
        guard = 0;
        while (pending_words.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (150)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_write(idx, val);
    endtask

    task automatic send_buffer(input int frames, input int extra, input int loud);
        int n;
        int i;
        logic [15:0] s;
        n = frames * ((m_chans > MAX_CHANNELS) ? MAX_CHANNELS : m_chans) + extra;
        if (n < 1)
            n = 1;
        for (i = 0; i < n; i++)
        begin
            s = 16'($urandom());
            if (loud == 0)
                s = 16'($urandom_range(0, 1200) - 600);
            else if (loud == 1)
                s = 16'($urandom_range(0, 16000) - 8000);
            send_sample(s, i == n - 1);
        end
    endtask

    task automatic test_directed;
        send_sample(16'h8000, 1'b1);
        drain();
        write_reg(CFG_ENABLE, 32'd1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b1);
        send_sample(16'h0100, 1'b0);
        send_sample(16'h0200, 1'b0);
        send_sample(16'h4000, 1'b1);
        send_sample(16'h0005, 1'b0);
        send_sample(16'h0003, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b1);
        drain();
        write_reg(CFG_CHANNELS, 32'd0);
        send_sample(16'h7000, 1'b0);
        send_sample(16'h7000, 1'b1);
        drain();
        write_reg(CFG_CHANNELS, 32'd15);
        send_buffer(2, 3, 2);
        drain();
        write_reg(CFG_CHANNELS, 32'd1);
    endtask

    task automatic test_extremes;
        write_reg(CFG_STREAM, 32'h1FFFF);
        write_reg(CFG_MAIN, 32'h1FFFF);
        write_reg(CFG_DECAY, 32'hFFFF_FFFF);
        write_reg(CFG_RISE, 32'hFFFF_FFFF);
        write_reg(CFG_FALL, 32'hFFFF_FFFF);
        send_buffer(3, 0, 0);
        send_buffer(2, 1, 2);
        drain();
        write_reg(CFG_DECAY, 32'd0);
        write_reg(CFG_RISE, 32'd0);
        write_reg(CFG_FALL, 32'd0);
        write_reg(CFG_STREAM, 32'd0);
        send_buffer(2, 0, 1);
        send_buffer(1, 0, 2);
        drain();
        write_reg(CFG_MAIN, 32'd0);
        write_reg(CFG_STREAM, 32'd65536);
        send_buffer(1, 0, 2);
        drain();
    endtask

    // long frame run gives powers with many exponent bits
    task automatic test_long_buffer;
        write_reg(CFG_CHANNELS, 32'd1);
        write_reg(CFG_MAIN, 32'd65536);
        write_reg(CFG_DECAY, 32'd2147468734);
        write_reg(CFG_RISE, 32'd2147499107);
        write_reg(CFG_FALL, 32'd2147271606);
        send_buffer(300, 0, 1);
        drain();
    endtask

    task automatic test_random;
        int k;
        int phase;
        for (phase = 0; phase < 6; phase++)
        begin
            write_reg(CFG_CHANNELS, $urandom_range(1, 9));
            write_reg(CFG_STREAM, $urandom_range(30000, 65536));
            write_reg(CFG_MAIN, (phase == 3) ? 32'h1FFFF : $urandom_range(30000, 65536));
            write_reg(CFG_DECAY, $urandom_range(32'h7000_0000, 32'h7FFF_FFFF));
            write_reg(CFG_RISE, $urandom_range(32'h8000_0000, 32'h9000_0000));
            write_reg(CFG_FALL, $urandom_range(32'h6000_0000, 32'h7FFF_FFFF));
            if (phase == 4)
                write_reg(CFG_ENABLE, 32'd0);
            if (phase == 5)
                write_reg(CFG_ENABLE, 32'd1);
            no_stall = (phase == 2);
            lull_max = (phase == 1) ? 0 : 6;
            for (k = 0; k < 11; k++)
                send_buffer($urandom_range(0, 6), $urandom_range(0, 2), $urandom_range(0, 2));
            drain();
        end
    endtask

    // receiver holds off so the job queue backs up and full rises
    task automatic test_backpressure;
        int k;
        lull_max = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (600)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            for (k = 0; k < 10; k++)
                send_buffer(1, 0, 2);
        join
        lull_max = 6;
        drain();
    endtask

    initial
    begin
        errors = 0;
        hold_off = 1'b0;
        no_stall = 1'b0;
        lull_max = 6;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        sample = '0;
        buffer_end = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_enable = 1'b0;
        m_chans = 4'd2;
        m_svol = 17'd65536;
        m_mvol = 17'd65536;
        m_decay = 32'd2147468734;
        m_rise = 32'd2147499107;
        m_fall = 32'd2147271606;
        m_buf_peak = '0;
        m_part_peak = '0;
        m_pos = 0;
        m_frames = 0;
        m_env = '0;
        m_gain = 32'd65536;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_extremes();
        test_long_buffer();
        test_random();
        test_backpressure();
        if (errors == 0 && pending_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/apag_pkg.sv
rtl/apag_jobq.sv
rtl/apag_front.sv
rtl/apag_back.sv
rtl/audio_peak_auto_gain.sv
tb/sv/audio_peak_auto_gain_tb.sv
